// File: design/bff_pkg.sv
// shared constants and codes for the boundary flood fill block
package bff_pkg;
   localparam int CANVAS_WIDTH  = 64;
   localparam int CANVAS_HEIGHT = 64;
   localparam int STACK_DEPTH   = 4096;
   localparam int X_BITS        = 6;
   localparam int Y_BITS        = 6;
   localparam int ADDR_BITS     = X_BITS + Y_BITS;
   localparam int PIXELS        = CANVAS_WIDTH * CANVAS_HEIGHT;
   localparam int SP_BITS       = $clog2(STACK_DEPTH + 1);
   localparam int SPI_BITS      = $clog2(STACK_DEPTH);
   localparam int COLOR_BITS    = 24;
   localparam int COUNT_BITS    = 13;

   localparam logic [1:0] CMD_WRITE = 2'd0;
   localparam logic [1:0] CMD_READ  = 2'd1;
   localparam logic [1:0] CMD_FILL  = 2'd2;

   typedef logic [COLOR_BITS-1:0] color_type;
endpackage

// File: design/boundary_flood_fill.sv
// boundary flood fill top level: canvas, pending stack and fill sequencer
// Usage: drive req_* and raise start while busy is low; the request is taken
// at that edge and busy rises. Commands: write pixel, read pixel, boundary fill.
// Every request gives one result: rsp_valid is high for exactly one cycle with
// rsp_pixel_value, rsp_filled_count and rsp_stack_overflow. The receiver
// cannot stall, so the result must be captured in that cycle.
// A fill ends without painting when the seed holds the boundary color. Otherwise
// its time grows with the pixels popped from the stack, the on-canvas neighbors
// checked and the off-canvas neighbors skipped (four per painted pixel after the
// seed). The fill time is set by the single port of the canvas memory: every
// pixel visit and neighbor check needs its own read through it.
// One request at a time; the next one can be taken in the cycle after the result.
// Reset: synchronous, active high. After reset a clearing pass writes zero to
// all 4096 canvas pixels, one per cycle, with busy high throughout.
// Off-canvas neighbors are never pushed; a push onto a full stack is dropped
// and flagged in rsp_stack_overflow.
module boundary_flood_fill (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_command,
   input  logic [5:0]  req_pos_x,
   input  logic [5:0]  req_pos_y,
   input  logic [23:0] req_paint_color,
   input  logic [23:0] req_edge_color,
   output logic        rsp_valid,
   output logic [23:0] rsp_pixel_value,
   output logic [12:0] rsp_filled_count,
   output logic        rsp_stack_overflow
);
   localparam logic [3:0] ST_CLEAR   = 4'd0;
   localparam logic [3:0] ST_IDLE    = 4'd1;
   localparam logic [3:0] ST_EXEC    = 4'd2;
   localparam logic [3:0] ST_RDDATA  = 4'd3;
   localparam logic [3:0] ST_SEED    = 4'd4;
   localparam logic [3:0] ST_NB      = 4'd5;
   localparam logic [3:0] ST_NBCHK   = 4'd6;
   localparam logic [3:0] ST_POP     = 4'd7;
   localparam logic [3:0] ST_POPSTK  = 4'd8;
   localparam logic [3:0] ST_POPPIX  = 4'd9;
   localparam logic [3:0] ST_DONE    = 4'd10;

   localparam int AB = bff_pkg::ADDR_BITS;
   localparam int XB = bff_pkg::X_BITS;
   localparam int SB = bff_pkg::SP_BITS;

   logic [3:0]  state_ff, state_in;
   logic [1:0]  cmd_ff;
   logic [XB-1:0] x_ff, x_in;
   logic [XB-1:0] y_ff, y_in;
   bff_pkg::color_type paint_ff, edge_ff, value_ff, value_in;
   logic [12:0] count_ff, count_in;
   logic        ovf_ff, ovf_in;
   logic        check_ff, check_in;
   logic [1:0]  nb_ff, nb_in;
   logic [SB-1:0] sp_ff, sp_in;
   logic [AB-1:0] clr_ff, clr_in;

   // canvas memory
   bff_pkg::color_type frame_mem [bff_pkg::PIXELS];
   bff_pkg::color_type fr_rd_ff, fr_wdata;
   logic [AB-1:0] fr_addr;
   logic          fr_we;

   // pending stack memory
   logic [AB-1:0] stack_mem [bff_pkg::STACK_DEPTH];
   logic [AB-1:0] st_rd_ff, st_wdata;
   logic [bff_pkg::SPI_BITS-1:0] st_addr;
   logic          st_we;

   always_ff @(posedge clock) begin
      if (fr_we) frame_mem[fr_addr] <= fr_wdata;
      fr_rd_ff <= frame_mem[fr_addr];
   end

   always_ff @(posedge clock) begin
      if (st_we) stack_mem[st_addr] <= st_wdata;
      st_rd_ff <= stack_mem[st_addr];
   end

   // neighbor of the current pixel in order x+1, x-1, y+1, y-1
   logic [XB-1:0] nx, ny;
   logic          n_on;
   always_comb begin
      nx   = x_ff;
      ny   = y_ff;
      n_on = 1'b1;
      case (nb_ff)
         2'd0: begin
            nx   = x_ff + 1'b1;
            n_on = (x_ff != XB'(bff_pkg::CANVAS_WIDTH - 1));
         end
         2'd1: begin
            nx   = x_ff - 1'b1;
            n_on = (x_ff != '0);
         end
         2'd2: begin
            ny   = y_ff + 1'b1;
            n_on = (y_ff != XB'(bff_pkg::CANVAS_HEIGHT - 1));
         end
         default: begin
            ny   = y_ff - 1'b1;
            n_on = (y_ff != '0);
         end
      endcase
   end

   logic [AB-1:0] cur_addr, nb_addr;
   assign cur_addr = {y_ff, x_ff};
   assign nb_addr  = {ny, nx};

   logic push, stack_full, nb_last;
   assign stack_full = (sp_ff == SB'(bff_pkg::STACK_DEPTH));
   assign nb_last    = (nb_ff == 2'd3);

   always_comb begin
      state_in = state_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      value_in = value_ff;
      count_in = count_ff;
      ovf_in   = ovf_ff;
      check_in = check_ff;
      nb_in    = nb_ff;
      sp_in    = sp_ff;
      clr_in   = clr_ff;
      fr_addr  = cur_addr;
      fr_we    = 1'b0;
      fr_wdata = paint_ff;
      st_addr  = sp_ff[bff_pkg::SPI_BITS-1:0];
      st_we    = 1'b0;
      st_wdata = nb_addr;
      push     = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            fr_addr  = clr_ff;
            fr_we    = 1'b1;
            fr_wdata = '0;
            clr_in   = clr_ff + 1'b1;
            if (clr_ff == AB'(bff_pkg::PIXELS - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start) begin
               x_in     = req_pos_x;
               y_in     = req_pos_y;
               value_in = '0;
               count_in = '0;
               ovf_in   = 1'b0;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            case (cmd_ff)
               bff_pkg::CMD_WRITE: begin
                  fr_we    = 1'b1;
                  state_in = ST_DONE;
               end
               bff_pkg::CMD_READ: state_in = ST_RDDATA;
               bff_pkg::CMD_FILL: state_in = ST_SEED;
               default:           state_in = ST_DONE;
            endcase
         end
         ST_RDDATA: begin
            value_in = fr_rd_ff;
            state_in = ST_DONE;
         end
         ST_SEED: begin
            if (fr_rd_ff == edge_ff) begin
               state_in = ST_DONE;
            end else begin
               fr_we    = 1'b1;
               count_in = 13'd1;
               sp_in    = '0;
               nb_in    = 2'd0;
               check_in = 1'b0;
               state_in = ST_NB;
            end
         end
         ST_NB: begin
            if (n_on && check_ff) begin
               fr_addr  = nb_addr;
               state_in = ST_NBCHK;
            end else begin
               push  = n_on;
               nb_in = nb_ff + 1'b1;
               if (nb_last) state_in = ST_POP;
            end
         end
         ST_NBCHK: begin
            push     = (fr_rd_ff != paint_ff);
            nb_in    = nb_ff + 1'b1;
            state_in = nb_last ? ST_POP : ST_NB;
         end
         ST_POP: begin
            if (sp_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               sp_in    = sp_ff - 1'b1;
               st_addr  = sp_in[bff_pkg::SPI_BITS-1:0];
               state_in = ST_POPSTK;
            end
         end
         ST_POPSTK: begin
            fr_addr  = st_rd_ff;
            x_in     = st_rd_ff[XB-1:0];
            y_in     = st_rd_ff[AB-1:XB];
            state_in = ST_POPPIX;
         end
         ST_POPPIX: begin
            if (fr_rd_ff == edge_ff || fr_rd_ff == paint_ff) begin
               state_in = ST_POP;
            end else begin
               fr_we    = 1'b1;
               if (count_ff != '1) count_in = count_ff + 1'b1;
               nb_in    = 2'd0;
               check_in = 1'b1;
               state_in = ST_NB;
            end
         end
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
      // a push onto a full stack is dropped and flagged
      if (push) begin
         if (stack_full) begin
            ovf_in = 1'b1;
         end else begin
            st_we = 1'b1;
            sp_in = sp_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         sp_ff    <= '0;
         nb_ff    <= '0;
         check_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         sp_ff    <= sp_in;
         nb_ff    <= nb_in;
         check_ff <= check_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && start) begin
         cmd_ff   <= req_command;
         paint_ff <= req_paint_color;
         edge_ff  <= req_edge_color;
      end
      x_ff     <= x_in;
      y_ff     <= y_in;
      value_ff <= value_in;
      count_ff <= count_in;
      ovf_ff   <= ovf_in;
   end

   assign busy               = (state_ff != ST_IDLE);
   assign rsp_valid          = (state_ff == ST_DONE);
   assign rsp_pixel_value    = value_ff;
   assign rsp_filled_count   = count_ff;
   assign rsp_stack_overflow = ovf_ff;

   a_strobe_one: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result strobe longer than one cycle");
   a_take_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("request taken without busy");
   a_count_fill: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_filled_count != '0 || rsp_stack_overflow))
         |-> cmd_ff == bff_pkg::CMD_FILL) else $error("fill result on other command");
   a_value_read: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_pixel_value != '0) |-> cmd_ff == bff_pkg::CMD_READ)
      else $error("pixel value on non-read command");
endmodule
